// File: rtl/ndt_pkg.sv
// Package for the N-dimensional transpose address generator.
// Holds shared widths, register codes, the control state type and the cell structs.
// No dependencies.
package ndt_pkg;

    // Index and configuration widths.
    localparam int IDX_W         = 48;
    localparam int CFG_CNT_W     = 3;
    localparam int CFG_SIZE_W    = 12;
    localparam int CFG_ORDER_W   = 8;
    localparam int NUM_SIZE_REGS = 4;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;
    localparam int REG_IDX_W     = 3;

    // Register indexes on the configuration port.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_DIM_COUNT  = 3'd0,
        REG_DIM_SIZE_0 = 3'd1,
        REG_DIM_SIZE_1 = 3'd2,
        REG_DIM_SIZE_2 = 3'd3,
        REG_DIM_SIZE_3 = 3'd4,
        REG_DIM_ORDER  = 3'd5
    } reg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_CNT_W-1:0]   DIM_COUNT_RST = 3'd1;
    localparam logic [CFG_SIZE_W-1:0]  DIM_SIZE_RST  = 12'd1;
    localparam logic [CFG_ORDER_W-1:0] DIM_ORDER_RST = 8'hE4;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } st_t;

    // Control handed to each cell of the chain.
    typedef struct packed {
        logic clear;     // New walk: clear both digits.
        logic in_use;    // Dimension slot is below the dimension count.
        logic src_step;  // Carry reaches this source digit.
        logic dst_step;  // This destination digit is touched by the carry.
        logic dst_zero;  // Last touch wrapped: digit goes to zero.
        logic dst_one;   // An earlier touch wrapped it first: digit goes to one.
    } cell_ctl_t;

    // Status returned by each cell.
    typedef struct packed {
        logic wrap;      // Source digit plus one equals its extent.
        logic src_nz;    // Source digit is nonzero.
    } cell_sts_t;

endpackage

// File: rtl/ndt_cell.sv
// One cell of the address chain: a source digit, a destination digit and one
// stage of the weighted digit sum. Depends on ndt_pkg.
module ndt_cell #(
    parameter int SIZE_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ndt_pkg::cell_ctl_t       ctl,
    output ndt_pkg::cell_sts_t       sts,
    input  logic [SIZE_BITS-1:0]     src_size,
    input  logic [SIZE_BITS:0]       dst_size,
    input  logic [ndt_pkg::IDX_W-1:0] w_in,
    input  logic [ndt_pkg::IDX_W-1:0] sum_in,
    input  logic [ndt_pkg::IDX_W-1:0] term_in,
    output logic [ndt_pkg::IDX_W-1:0] w_out,
    output logic [ndt_pkg::IDX_W-1:0] sum_out,
    output logic [ndt_pkg::IDX_W-1:0] term_out
);
    import ndt_pkg::*;

    logic [SIZE_BITS-1:0]         src_reg, src_next;
    logic [SIZE_BITS-1:0]         dst_reg, dst_next;
    logic [SIZE_BITS-1:0]         src_inc;
    logic [SIZE_BITS-1:0]         dst_eff;
    logic [IDX_W+SIZE_BITS:0]     w_prod;
    logic [IDX_W+SIZE_BITS-1:0]   t_prod;
    logic [IDX_W-1:0]             w_reg, w_next;
    logic [IDX_W-1:0]             term_reg, term_next;
    logic [IDX_W-1:0]             sum_reg, sum_next;

    // The source digit counts modulo 2^SIZE_BITS and wraps when it meets its extent.
    assign src_inc    = src_reg + 1'b1;
    assign sts.wrap   = (src_inc == src_size);
    assign sts.src_nz = |src_reg;

    always_comb begin
        priority if (ctl.clear) begin
            src_next = '0;
        end else if (ctl.src_step) begin
            src_next = sts.wrap ? '0 : src_inc;
        end else begin
            src_next = src_reg;
        end
    end

    // The destination digit follows the carry through the permutation.
    always_comb begin
        priority if (ctl.clear) begin
            dst_next = '0;
        end else if (ctl.dst_step && ctl.dst_zero) begin
            dst_next = '0;
        end else if (ctl.dst_step && ctl.dst_one) begin
            dst_next = SIZE_BITS'(1);
        end else if (ctl.dst_step) begin
            dst_next = dst_reg + 1'b1;
        end else begin
            dst_next = dst_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg <= '0;
            dst_reg <= '0;
        end else begin
            src_reg <= src_next;
            dst_reg <= dst_next;
        end
    end

    // One stage of the digit sum: next weight, this digit's term, and the running sum.
    assign dst_eff   = ctl.in_use ? dst_reg : '0;
    assign w_prod    = w_in * dst_size;
    assign t_prod    = w_in * dst_eff;
    assign w_next    = w_prod[IDX_W-1:0];
    assign term_next = t_prod[IDX_W-1:0];
    assign sum_next  = sum_in + term_in;

    always_ff @(posedge aclk) begin
        w_reg    <= w_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
    end

    assign w_out    = w_reg;
    assign term_out = term_reg;
    assign sum_out  = sum_reg;

endmodule

// File: rtl/nd_transpose_address_generator.sv
// Top level of the N-dimensional transpose address generator.
// Holds the configuration registers, the sequencer and the chain of ndt_cell.
// Depends on ndt_pkg and ndt_cell.
//
// Usage: each beat on the s_ channel is one step of a walk over the source
// array in linear order; s_restart high starts a new walk at the first cell.
// For every input beat exactly one beat leaves on the m_ channel with the
// linear index of that cell in the permuted layout, and m_last high when the
// whole source counter wrapped after that cell.
// Operation: when the fastest source digit is nonzero the index is the previous
// one plus a stored stride; the beat is accepted in ST_IDLE, the index is formed
// in ST_CALC and written to the output register as the item finishes there.
// On a new walk or at the start of each row the index is rebuilt by the
// chain of MAX_DIMS cells, one registered multiply stage per cell; the
// item stays in ST_CALC until the wave has crossed every cell, and it
// returns to ST_IDLE for the next beat. One item is in flight at a time.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls, the following result is held until the
// output register frees. Reset clears the digits and the sequencer and loads
// the register defaults (one dimension of extent 1, identity order); the
// first item after reset always starts a new walk.
module nd_transpose_address_generator #(
    parameter int MAX_DIMS  = 4,
    parameter int SIZE_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ndt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ndt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ndt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_restart,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ndt_pkg::IDX_W-1:0]       m_dest_index,
    output logic                            m_last
);
    import ndt_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_DIMS + 1);

    // Configuration registers.
    logic [CFG_CNT_W-1:0]   dim_count_reg;
    logic [CFG_SIZE_W-1:0]  dim_size_reg [NUM_SIZE_REGS];
    logic [CFG_ORDER_W-1:0] dim_order_reg;
    logic                   cfg_wr;
    reg_idx_t               reg_idx;

    // Sequencer and result state.
    st_t                    state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   fast_reg, fast_next;
    logic                   new_walk_reg, new_walk_next;
    logic                   started_reg, started_next;
    logic [IDX_W-1:0]       prev_reg, prev_next;
    logic [IDX_W-1:0]       stride_reg, stride_next;
    logic                   m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]       m_dest_index_reg, m_dest_index_next;
    logic                   m_last_reg, m_last_next;

    logic                   accept;
    logic                   finish;
    logic                   ready_int;
    logic                   new_walk;
    logic [CFG_CNT_W-1:0]   n_used;
    logic [IDX_W-1:0]       idx_calc;
    logic [IDX_W-1:0]       stride_sel;
    logic                   last_flag;

    // Per-dimension views.
    logic [SIZE_BITS-1:0]   src_size [MAX_DIMS];
    logic [SIZE_BITS:0]     src_eff  [MAX_DIMS];
    logic [1:0]             dpos     [MAX_DIMS];
    logic [SIZE_BITS:0]     dst_size [MAX_DIMS];
    logic [MAX_DIMS-1:0]    in_use;
    logic [MAX_DIMS-1:0]    chain_v;
    logic [MAX_DIMS-1:0]    dst_step, dst_zero, dst_one;
    cell_ctl_t              ctl [MAX_DIMS];
    cell_sts_t              sts [MAX_DIMS];

    // Wave signals along the chain; slot 0 feeds the first cell.
    logic [IDX_W-1:0]       w_chain    [MAX_DIMS+1];
    logic [IDX_W-1:0]       sum_chain  [MAX_DIMS+1];
    logic [IDX_W-1:0]       term_chain [MAX_DIMS+1];

    // ---------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; no wait states.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_count_reg <= DIM_COUNT_RST;
            for (int k = 0; k < NUM_SIZE_REGS; k++) begin
                dim_size_reg[k] <= DIM_SIZE_RST;
            end
            dim_order_reg <= DIM_ORDER_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_DIM_COUNT:  dim_count_reg   <= pwdata[CFG_CNT_W-1:0];
                REG_DIM_SIZE_0: dim_size_reg[0] <= pwdata[CFG_SIZE_W-1:0];
                REG_DIM_SIZE_1: dim_size_reg[1] <= pwdata[CFG_SIZE_W-1:0];
                REG_DIM_SIZE_2: dim_size_reg[2] <= pwdata[CFG_SIZE_W-1:0];
                REG_DIM_SIZE_3: dim_size_reg[3] <= pwdata[CFG_SIZE_W-1:0];
                REG_DIM_ORDER:  dim_order_reg   <= pwdata[CFG_ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data is returned combinationally in the access phase.
    always_comb begin
        unique case (reg_idx)
            REG_DIM_COUNT:  prdata = APB_DATA_W'(dim_count_reg);
            REG_DIM_SIZE_0: prdata = APB_DATA_W'(dim_size_reg[0]);
            REG_DIM_SIZE_1: prdata = APB_DATA_W'(dim_size_reg[1]);
            REG_DIM_SIZE_2: prdata = APB_DATA_W'(dim_size_reg[2]);
            REG_DIM_SIZE_3: prdata = APB_DATA_W'(dim_size_reg[3]);
            REG_DIM_ORDER:  prdata = APB_DATA_W'(dim_order_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Number of dimensions in use: zero counts as one, and the count saturates.
    always_comb begin
        priority if (dim_count_reg == '0) begin
            n_used = CFG_CNT_W'(1);
        end else if (dim_count_reg > CFG_CNT_W'(MAX_DIMS)) begin
            n_used = CFG_CNT_W'(MAX_DIMS);
        end else begin
            n_used = dim_count_reg;
        end
    end

    // Extents keep their low SIZE_BITS bits; a zero extent acts as 2^SIZE_BITS.
    for (genvar gi = 0; gi < MAX_DIMS; gi++) begin : g_dim
        logic [SIZE_BITS+CFG_SIZE_W-1:0] size_ext;
        assign size_ext     = {{SIZE_BITS{1'b0}}, dim_size_reg[gi]};
        assign src_size[gi] = size_ext[SIZE_BITS-1:0];
        assign src_eff[gi]  = {(src_size[gi] == '0), src_size[gi]};
        assign dpos[gi]     = dim_order_reg[2*gi +: 2];
        assign in_use[gi]   = (CFG_CNT_W'(gi) < n_used);
    end

    // Destination extents: a later source dimension overrides an earlier one.
    always_comb begin
        for (int p = 0; p < MAX_DIMS; p++) begin
            dst_size[p] = (SIZE_BITS+1)'(1);
            for (int i = 0; i < MAX_DIMS; i++) begin
                if (in_use[i] && (dpos[i] == 2'(p)) && in_use[p]) begin
                    dst_size[p] = src_eff[i];
                end
            end
        end
    end

    // Carry chain over the source digits, fastest first.
    always_comb begin
        chain_v[0] = 1'b1;
        for (int i = 1; i < MAX_DIMS; i++) begin
            chain_v[i] = chain_v[i-1] && sts[i-1].wrap && in_use[i];
        end
        last_flag = 1'b0;
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (chain_v[i] && sts[i].wrap && (CFG_CNT_W'(i + 1) == n_used)) begin
                last_flag = 1'b1;
            end
        end
    end

    // Destination digit updates: the highest carried source dimension that maps
    // to a position decides it; any earlier one there has wrapped it to zero.
    always_comb begin
        logic seen;
        for (int p = 0; p < MAX_DIMS; p++) begin
            seen        = 1'b0;
            dst_step[p] = 1'b0;
            dst_zero[p] = 1'b0;
            dst_one[p]  = 1'b0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                if (chain_v[i] && (dpos[i] == 2'(p)) && in_use[p]) begin
                    dst_step[p] = 1'b1;
                    dst_zero[p] = sts[i].wrap;
                    dst_one[p]  = seen;
                    seen        = 1'b1;
                end
            end
        end
    end

    // Cell controls.
    assign new_walk = s_restart || !started_reg;

    for (genvar gi = 0; gi < MAX_DIMS; gi++) begin : g_ctl
        assign ctl[gi].clear    = accept && new_walk;
        assign ctl[gi].in_use   = in_use[gi];
        assign ctl[gi].src_step = finish && chain_v[gi];
        assign ctl[gi].dst_step = finish && dst_step[gi];
        assign ctl[gi].dst_zero = dst_zero[gi];
        assign ctl[gi].dst_one  = dst_one[gi];
    end

    // ---------------------------------------------------------------------
    // Chain of cells; the weight starts at one and the sum at zero.
    assign w_chain[0]    = IDX_W'(1);
    assign sum_chain[0]  = '0;
    assign term_chain[0] = '0;

    for (genvar gi = 0; gi < MAX_DIMS; gi++) begin : g_cell
        ndt_cell #(
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl[gi]),
            .sts      (sts[gi]),
            .src_size (src_size[gi]),
            .dst_size (dst_size[gi]),
            .w_in     (w_chain[gi]),
            .sum_in   (sum_chain[gi]),
            .term_in  (term_chain[gi]),
            .w_out    (w_chain[gi+1]),
            .sum_out  (sum_chain[gi+1]),
            .term_out (term_chain[gi+1])
        );
    end

    // Stride of source dimension 0: the weight at its destination position.
    always_comb begin
        stride_sel = w_chain[0];
        for (int k = 0; k <= MAX_DIMS; k++) begin
            if ((CFG_CNT_W'(dim_order_reg[1:0]) == CFG_CNT_W'(k)) ||
                ((k == MAX_DIMS) && (CFG_CNT_W'(dim_order_reg[1:0]) > CFG_CNT_W'(MAX_DIMS)))) begin
                stride_sel = w_chain[k];
            end
        end
    end

    // Index of the current cell: a step along the row, or the rebuilt sum.
    assign idx_calc = fast_reg ? (prev_reg + stride_reg)
                               : (sum_chain[MAX_DIMS] + term_chain[MAX_DIMS]);

    // ---------------------------------------------------------------------
    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CALC;
            ST_CALC: if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        ready_int = 1'b0;
        finish    = 1'b0;
        unique case (state_reg)
            ST_IDLE: ready_int = 1'b1;
            ST_CALC: finish    = (cnt_reg == '0) && (!m_valid_reg || m_ready);
            default: ;
        endcase
    end

    assign s_ready = ready_int;
    assign accept  = s_valid && ready_int;

    // Item bookkeeping: the rebuild waits for the wave to cross every cell.
    always_comb begin
        cnt_next      = cnt_reg;
        fast_next     = fast_reg;
        new_walk_next = new_walk_reg;
        started_next  = started_reg;
        if (accept) begin
            fast_next     = !new_walk && sts[0].src_nz;
            new_walk_next = new_walk;
            started_next  = 1'b1;
            cnt_next      = (!new_walk && sts[0].src_nz) ? '0 : CNT_BITS'(MAX_DIMS);
        end else if ((state_reg == ST_CALC) && (cnt_reg != '0)) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Result and walk state are written when the item finishes.
    always_comb begin
        prev_next         = prev_reg;
        stride_next       = stride_reg;
        m_dest_index_next = m_dest_index_reg;
        m_last_next       = m_last_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        if (finish) begin
            prev_next         = idx_calc;
            m_dest_index_next = idx_calc;
            m_last_next       = last_flag;
            m_valid_next      = 1'b1;
            if (new_walk_reg) begin
                stride_next = stride_sel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            fast_reg     <= 1'b0;
            new_walk_reg <= 1'b0;
            started_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fast_reg     <= fast_next;
            new_walk_reg <= new_walk_next;
            started_reg  <= started_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg         <= prev_next;
        stride_reg       <= stride_next;
        m_dest_index_reg <= m_dest_index_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_dest_index = m_dest_index_reg;
    assign m_last       = m_last_reg;

endmodule

// File: rtl/ndt_checker.sv
// Port-level checks for the N-dimensional transpose address generator,
// bound to the top level. Depends on ndt_pkg.
module ndt_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [ndt_pkg::IDX_W-1:0] m_dest_index,
    input logic                      m_last
);
    import ndt_pkg::*;

    // Reset leaves no result pending and the input side open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("ndt: result pending or input closed after reset");

    // One item at a time: an accepted beat closes the input for the next cycle.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ndt: input accepted while an item is in flight");

    // A stalled result beat stays valid.
    a_out_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("ndt: result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_dest_index) && $stable(m_last)))
        else $error("ndt: result payload changed while stalled");

endmodule

bind nd_transpose_address_generator ndt_checker u_ndt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_dest_index (m_dest_index),
    .m_last       (m_last)
);

// File: verif/nd_transpose_address_generator_test.sv
`timescale 1ns / 100ps
// Testbench for nd_transpose_address_generator: drives steps of source walks and checks
// every destination index and wrap flag against a built-in mixed-radix predictor.
// Depends on ndt_pkg and the RTL of the address generator.
module nd_transpose_address_generator_test;
    import ndt_pkg::*;

    localparam int  MAX_DIMS   = 4;
    localparam int  SETTLE     = MAX_DIMS + 4;
    localparam int  HOLD_LEN   = 300;
    localparam int  LIMIT      = 1000000;
    localparam int  RAND_STEPS = 440;

    // One beat of the result channel.
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             last;
    } dest_beat_t;

    // Mirrors the configuration and the walk state, predicts each result beat
    // and compares the beats that leave the block.
    class transpose_scoreboard;
        bit [CFG_CNT_W-1:0]   cnt;
        bit [CFG_SIZE_W-1:0]  size [MAX_DIMS];
        bit [CFG_ORDER_W-1:0] order;
        bit [CFG_SIZE_W-1:0]  src_dig [MAX_DIMS];
        bit [CFG_SIZE_W-1:0]  dst_dig [MAX_DIMS];
        bit [IDX_W-1:0]       stride0;
        bit [IDX_W-1:0]       prev_index;
        bit                   walking;
        dest_beat_t           expected_beats[$];
        int                   errors;
        int                   checked;
        int                   wraps;

        function new();
            int k;
            cnt = DIM_COUNT_RST;
            order = DIM_ORDER_RST;
            for (k = 0; k < MAX_DIMS; k++) begin
                size[k] = DIM_SIZE_RST;
                src_dig[k] = '0;
                dst_dig[k] = '0;
            end
            stride0 = '0;
            prev_index = '0;
            walking = 1'b0;
            errors = 0;
            checked = 0;
            wraps = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH: %s", msg);
        endtask

        function void set_reg(input reg_idx_t r, input bit [31:0] v);
            case (r)
                REG_DIM_COUNT:  cnt = v[CFG_CNT_W-1:0];
                REG_DIM_SIZE_0: size[0] = v[CFG_SIZE_W-1:0];
                REG_DIM_SIZE_1: size[1] = v[CFG_SIZE_W-1:0];
                REG_DIM_SIZE_2: size[2] = v[CFG_SIZE_W-1:0];
                REG_DIM_SIZE_3: size[3] = v[CFG_SIZE_W-1:0];
                REG_DIM_ORDER:  order = v[CFG_ORDER_W-1:0];
                default: ;
            endcase
        endfunction

        // A zero extent stands for the full digit range.
        function bit [IDX_W-1:0] extent(input int k);
            return (size[k] == '0) ? IDX_W'(1 << CFG_SIZE_W) : IDX_W'(size[k]);
        endfunction

        function int waiting();
            return expected_beats.size();
        endfunction

        // Advance the walk by one accepted step and queue the beat it must produce.
        function void note_step(input bit restart);
            int             n;
            int             k;
            bit [1:0]       p;
            bit [IDX_W-1:0] ds [MAX_DIMS];
            bit [IDX_W-1:0] w;
            dest_beat_t     beat;

            n = (cnt == 0) ? 1 : ((cnt > MAX_DIMS) ? MAX_DIMS : int'(cnt));
            for (k = 0; k < MAX_DIMS; k++) ds[k] = IDX_W'(1);
            // Later source dimensions overwrite earlier ones at a shared position.
            for (k = 0; k < n; k++) begin
                p = order[2*k +: 2];
                if (p < n) ds[p] = extent(k);
            end

            // New walk: clear digits and latch the stride of the fastest dimension.
            if (restart || !walking) begin
                for (k = 0; k < MAX_DIMS; k++) begin
                    src_dig[k] = '0;
                    dst_dig[k] = '0;
                end
                stride0 = IDX_W'(1);
                for (k = 0; k < int'(order[1:0]); k++) stride0 = stride0 * ds[k];
                walking = 1'b1;
            end

            // Inside a row the index only steps by the stride, otherwise rebuild it.
            if (src_dig[0] != '0) begin
                beat.index = prev_index + stride0;
            end else begin
                beat.index = '0;
                w = IDX_W'(1);
                for (k = 0; k < n; k++) begin
                    beat.index = beat.index + dst_dig[k] * w;
                    w = w * ds[k];
                end
            end
            prev_index = beat.index;

            // Ripple the carry through both digit sets.
            beat.last = 1'b0;
            for (k = 0; k < n; k++) begin
                p = order[2*k +: 2];
                src_dig[k] = src_dig[k] + 1'b1;
                if (p < n) dst_dig[p] = dst_dig[p] + 1'b1;
                if (src_dig[k] == size[k]) begin
                    src_dig[k] = '0;
                    if (p < n) dst_dig[p] = '0;
                    if (k == n - 1) beat.last = 1'b1;
                end else begin
                    break;
                end
            end
            expected_beats = {expected_beats, beat};
        endfunction

        // Compare one accepted result beat with the oldest expectation.
        task check_beat(input logic [IDX_W-1:0] index, input logic last);
            dest_beat_t want;
            if (expected_beats.size() == 0) begin
                report($sformatf("result beat index %0h with no step waiting", index));
            end else begin
                want = expected_beats.pop_front();
                checked++;
                if (want.last) wraps++;
                if (index !== want.index)
                    report($sformatf("beat %0d: index %0h, want %0h", checked, index,
                                     want.index));
                if (last !== want.last)
                    report($sformatf("beat %0d: last %b, want %b", checked, last,
                                     want.last));
            end
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_restart;
    logic                   m_valid;
    logic                   m_ready;
    logic [IDX_W-1:0]       m_dest_index;
    logic                   m_last;

    transpose_scoreboard board;
    bit  src_idle_en;
    bit  sink_idle_en;
    bit  hold_req;
    int  cycles;
    int  steps_sent;
    int  settings_run;

    nd_transpose_address_generator #(
        .MAX_DIMS (MAX_DIMS),
        .SIZE_BITS(CFG_SIZE_W)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dest_index(m_dest_index),
        .m_last      (m_last)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, a long hold-off on request, or always ready.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge aclk);
            end else if (sink_idle_en) begin
                m_ready <= ($urandom_range(99) >= 35);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result beats are checked at the edge that accepts them.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_beat(m_dest_index, m_last);
    end

    // Offer one step, with random idle cycles ahead of it, and wait for the accept.
    task automatic send_step(input bit restart);
        @(negedge aclk);
        while (src_idle_en && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            s_restart <= 1'($urandom);
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        board.note_step(restart);
        steps_sent++;
    endtask

    // Stop offering and wait until every expected beat has arrived.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.waiting() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write one register with noise in the unused bits, then read it back.
    task automatic write_reg(input reg_idx_t r, input bit [31:0] value);
        bit [31:0] mask;
        bit [31:0] data;
        bit [31:0] rd;
        case (r)
            REG_DIM_COUNT: mask = 32'h7;
            REG_DIM_ORDER: mask = 32'hFF;
            default:       mask = 32'hFFF;
        endcase
        data = (value & mask) | ($urandom & ~mask);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * int'(r));
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_reg(r, data);
        // Read back over the same address.
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        pwdata <= $urandom;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== (data & mask))
            board.report($sformatf("register %s reads %0h, want %0h", r.name(), rd,
                                   data & mask));
    endtask

    task automatic set_shape(input bit [2:0] cnt, input bit [11:0] s0, input bit [11:0] s1,
                             input bit [11:0] s2, input bit [11:0] s3, input bit [7:0] ord);
        write_reg(REG_DIM_COUNT, 32'(cnt));
        write_reg(REG_DIM_SIZE_0, 32'(s0));
        write_reg(REG_DIM_SIZE_1, 32'(s1));
        write_reg(REG_DIM_SIZE_2, 32'(s2));
        write_reg(REG_DIM_SIZE_3, 32'(s3));
        write_reg(REG_DIM_ORDER, 32'(ord));
        settings_run++;
    endtask

    // One random setting followed by a few walks, mostly well formed.
    task automatic random_phase(input bit pressure, inout int budget);
        bit [2:0]  cnt;
        bit [11:0] sz [MAX_DIMS];
        bit [7:0]  ord;
        int        pos [MAX_DIMS];
        int        n, k, j, t, walks, len, roll;
        longint    total;

        cnt = ($urandom_range(99) < 85) ? 3'($urandom_range(MAX_DIMS, 1)) : 3'($urandom);
        n = (cnt == 0) ? 1 : ((cnt > MAX_DIMS) ? MAX_DIMS : int'(cnt));
        for (k = 0; k < MAX_DIMS; k++) begin
            roll = $urandom_range(99);
            if (roll < 75) sz[k] = 12'($urandom_range(5, 1));
            else if (roll < 88) sz[k] = 12'($urandom_range(40, 6));
            else if (roll < 94) sz[k] = ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
            else sz[k] = 12'($urandom);
        end
        // Mostly a true permutation of the dimensions in use.
        if ($urandom_range(99) < 70) begin
            for (k = 0; k < MAX_DIMS; k++) pos[k] = k;
            for (k = n - 1; k > 0; k--) begin
                j = $urandom_range(k, 0);
                t = pos[k];
                pos[k] = pos[j];
                pos[j] = t;
            end
            for (k = 0; k < MAX_DIMS; k++) ord[2*k +: 2] = 2'(pos[k]);
        end else begin
            ord = 8'($urandom);
        end
        set_shape(cnt, sz[0], sz[1], sz[2], sz[3], ord);

        total = 1;
        for (k = 0; k < n; k++) total = total * ((sz[k] == 0) ? 4096 : sz[k]);

        src_idle_en = ($urandom_range(99) < 85);
        sink_idle_en = ($urandom_range(99) < 85);
        if (pressure) begin
            src_idle_en = 1'b0;
            hold_req = 1'b1;
        end

        walks = $urandom_range(4, 2);
        for (j = 0; j < walks; j++) begin
            if (total <= 48) len = int'(total) * $urandom_range(2, 1) + $urandom_range(2, 0);
            else len = $urandom_range(40, 10);
            // Under the hold-off, offer enough steps to fill the block.
            if (pressure && len < 8) len = 8;
            // A walk normally opens with a restart; sometimes it just carries on.
            send_step($urandom_range(99) < 90);
            for (k = 1; k < len; k++) send_step($urandom_range(99) < 3);
            budget += len;
        end
        drain();
    endtask

    initial begin
        int done_random;
        int k;

        board = new();
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_restart = 1'b0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        hold_req = 1'b0;
        steps_sent = 0;
        settings_run = 0;
        done_random = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: the very first step starts a walk even without restart.
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b1);
        drain();

        // Three dimensions under a true permutation, one full walk and its wrap.
        set_shape(3'd3, 12'd2, 12'd3, 12'd2, 12'd1, 8'hD2);
        send_step(1'b1);
        for (k = 0; k < 11; k++) send_step(1'b0);
        drain();

        // Dimension count of zero acts as one dimension.
        set_shape(3'd0, 12'd3, 12'd1, 12'd1, 12'd1, 8'hE4);
        send_step(1'b1);
        for (k = 0; k < 3; k++) send_step(1'b0);
        drain();

        // Count above the maximum, extreme extents and an order that is no permutation.
        set_shape(3'd7, 12'hFFF, 12'h000, 12'd2, 12'd1, 8'h00);
        send_step(1'b1);
        for (k = 0; k < 3; k++) send_step(1'b0);
        drain();

        // Leave the second digit at 7, then shrink its extent to zero mid walk:
        // the digit keeps counting past its old extent, with no idling on either side.
        set_shape(3'd2, 12'd1, 12'd10, 12'd1, 12'd1, 8'hE4);
        send_step(1'b1);
        for (k = 0; k < 6; k++) send_step(1'b0);
        drain();
        write_reg(REG_DIM_SIZE_1, 32'h0);
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        for (k = 0; k < 40; k++) send_step(1'b0);
        drain();

        // Random settings; the first one runs against a long receiver hold-off.
        random_phase(1'b1, done_random);
        while (done_random < RAND_STEPS) random_phase(1'b0, done_random);

        drain();
        repeat (4 * SETTLE) @(posedge aclk);

        $display("Run covered %0d steps under %0d settings, %0d beats with a full wrap.",
                 steps_sent, settings_run, board.wraps);
        $display("It included a long receiver hold, zero extents and digits beyond extent.");
        if (board.errors == 0 && board.waiting() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
